/* hdl/ffca_pkg.sv */
`default_nettype none

package ffca_pkg;

   localparam int SLOTS      = 1024;
   localparam int VALUE_BITS = 32;

   // fixed widths of the transaction fields
   localparam int KIND_BITS       = 1;
   localparam int SLOT_BITS       = 10;
   localparam int AMOUNT_BITS     = 32;
   localparam int SLOT_COUNT_BITS = 11;
   localparam int GRANT_BITS      = 11;

   localparam logic [SLOT_COUNT_BITS-1:0] SLOT_COUNT_RESET = 11'd1024;

   // tree geometry: root at node 1, leaves from LEAF_BASE upwards
   localparam int LEVELS     = $clog2(SLOTS);
   localparam int NODE_BITS  = LEVELS + 1;
   localparam int TREE_NODES = 1 << NODE_BITS;
   localparam int LEAF_BASE  = 1 << LEVELS;

   localparam logic [KIND_BITS-1:0] KIND_LOAD    = 1'b0;
   localparam logic [KIND_BITS-1:0] KIND_REQUEST = 1'b1;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_FETCH,
      S_DESCEND,
      S_GRANT,
      S_UPDATE,
      S_EMIT
   } state_type;

   typedef struct packed {
      logic clear_step;
      logic start;
      logic fetch;
      logic descend;
      logic grant;
      logic update;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic in_request;
      logic in_slot_ok;
      logic item_request;
      logic miss;
      logic next_leaf;
      logic grant_ok;
      logic at_root;
      logic rsp_free;
   } stat_type;

endpackage

`default_nettype wire

/* hdl/ffca_if.sv */
`default_nettype none

interface ffca_req_if import ffca_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [KIND_BITS-1:0]   kind;
   logic [SLOT_BITS-1:0]   slot_index;
   logic [AMOUNT_BITS-1:0] amount;

   modport source (output valid, kind, slot_index, amount, input ready);
   modport sink   (input valid, kind, slot_index, amount, output ready);
endinterface

interface ffca_rsp_if import ffca_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [GRANT_BITS-1:0] granted_slot;

   modport source (output valid, granted_slot, input ready);
   modport sink   (input valid, granted_slot, output ready);
endinterface

`default_nettype wire

/* hdl/ffca_ctrl.sv */
`default_nettype none

module ffca_ctrl import ffca_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   input  wire stat_type stat,
   output logic          req_ready,
   output cmd_type       cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (stat.clear_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               if (stat.in_request)      state_in = S_FETCH;
               else if (stat.in_slot_ok) state_in = S_UPDATE;
            end
         end
         S_FETCH: begin
            state_in = S_DESCEND;
         end
         S_DESCEND: begin
            if (stat.miss)           state_in = S_EMIT;
            else if (stat.next_leaf) state_in = S_GRANT;
         end
         S_GRANT: begin
            state_in = stat.grant_ok ? S_UPDATE : S_EMIT;
         end
         S_UPDATE: begin
            if (stat.at_root) state_in = stat.item_request ? S_EMIT : S_IDLE;
         end
         S_EMIT: begin
            if (stat.rsp_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            cmd.start = req_valid;
         end
         S_FETCH: begin
            cmd.fetch = 1'b1;
         end
         S_DESCEND: begin
            cmd.descend = 1'b1;
         end
         S_GRANT: begin
            cmd.grant = 1'b1;
         end
         S_UPDATE: begin
            cmd.update = 1'b1;
         end
         S_EMIT: begin
            cmd.emit = stat.rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

/* hdl/ffca_dp.sv */
`default_nettype none

module ffca_dp import ffca_pkg::*; (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire cmd_type                    cmd,
   input  wire logic                       csr_write_en,
   input  wire logic [SLOT_COUNT_BITS-1:0] csr_write_data,
   input  wire logic [KIND_BITS-1:0]       req_kind,
   input  wire logic [SLOT_BITS-1:0]       req_slot_index,
   input  wire logic [AMOUNT_BITS-1:0]     req_amount,
   input  wire logic                       rsp_ready,
   output stat_type                        stat,
   output logic                            rsp_valid,
   output logic [GRANT_BITS-1:0]           rsp_granted_slot
);

   logic [VALUE_BITS-1:0]      tree_ff [TREE_NODES];
   logic [VALUE_BITS-1:0]      rd_a_ff;
   logic [VALUE_BITS-1:0]      rd_b_ff;
   logic [NODE_BITS-1:0]       clr_addr_ff;
   logic [SLOT_COUNT_BITS-1:0] slot_count_ff;
   logic                       rsp_valid_ff;
   logic [GRANT_BITS-1:0]      rsp_slot_ff;
   logic [KIND_BITS-1:0]       kind_ff;
   logic [VALUE_BITS-1:0]      amount_ff;
   logic [NODE_BITS-1:0]       node_ff;
   logic [VALUE_BITS-1:0]      val_ff;
   logic                       first_ff;
   logic [GRANT_BITS-1:0]      res_ff;

   logic                       left_fit;
   logic                       right_fit;
   logic [NODE_BITS-1:0]       chosen;
   logic [VALUE_BITS-1:0]      chosen_val;
   logic [LEVELS-1:0]          found;
   logic                       grant_ok;
   logic [VALUE_BITS-1:0]      wval;
   logic                       mem_we;
   logic [NODE_BITS-1:0]       mem_waddr;
   logic [VALUE_BITS-1:0]      mem_wdata;
   logic [NODE_BITS-1:0]       rd_addr_a;
   logic [NODE_BITS-1:0]       rd_addr_b;
   logic [NODE_BITS-1:0]       load_leaf;

   // descent: read data holds both children of node_ff
   assign left_fit   = rd_a_ff >= amount_ff;
   assign right_fit  = rd_b_ff >= amount_ff;
   assign chosen     = {node_ff[NODE_BITS-2:0], ~left_fit};
   assign chosen_val = left_fit ? rd_a_ff : rd_b_ff;

   assign found    = node_ff[LEVELS-1:0];
   assign grant_ok = (32'(found) < 32'(slot_count_ff)) && (32'(found) < SLOTS);

   // climbing: rd_a_ff holds the sibling of the child just written
   assign wval = (first_ff || val_ff > rd_a_ff) ? val_ff : rd_a_ff;

   assign load_leaf = NODE_BITS'(LEAF_BASE + 32'(req_slot_index));

   always_comb begin
      mem_we    = cmd.clear_step || cmd.update;
      mem_waddr = cmd.clear_step ? clr_addr_ff : node_ff;
      mem_wdata = cmd.clear_step ? '0 : wval;
   end

   always_comb begin
      rd_addr_a = {node_ff[NODE_BITS-2:0], 1'b0};
      rd_addr_b = {node_ff[NODE_BITS-2:0], 1'b1};
      if (cmd.descend) begin
         rd_addr_a = {chosen[NODE_BITS-2:0], 1'b0};
         rd_addr_b = {chosen[NODE_BITS-2:0], 1'b1};
      end else if (cmd.update) begin
         rd_addr_a = node_ff ^ NODE_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         tree_ff[mem_waddr] <= mem_wdata;
      end
      rd_a_ff <= tree_ff[rd_addr_a];
      rd_b_ff <= tree_ff[rd_addr_b];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff   <= '0;
         slot_count_ff <= SLOT_COUNT_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cmd.clear_step) clr_addr_ff <= clr_addr_ff + NODE_BITS'(1);
         if (csr_write_en)   slot_count_ff <= csr_write_data;
         if (cmd.emit)           rsp_valid_ff <= 1'b1;
         else if (rsp_ready)     rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) rsp_slot_ff <= res_ff;
      if (cmd.start) begin
         kind_ff   <= req_kind;
         amount_ff <= VALUE_BITS'(req_amount);
         res_ff    <= '0;
         first_ff  <= 1'b1;
         if (req_kind == KIND_REQUEST) begin
            node_ff <= NODE_BITS'(1);
         end else begin
            node_ff <= load_leaf;
            val_ff  <= VALUE_BITS'(req_amount);
         end
      end else if (cmd.descend) begin
         if (left_fit || right_fit) begin
            node_ff <= chosen;
            val_ff  <= chosen_val;
         end
      end else if (cmd.grant) begin
         val_ff   <= val_ff - amount_ff;
         first_ff <= 1'b1;
         if (grant_ok) res_ff <= GRANT_BITS'(32'(found) + 32'd1);
      end else if (cmd.update) begin
         node_ff  <= node_ff >> 1;
         val_ff   <= wval;
         first_ff <= 1'b0;
      end
   end

   always_comb begin
      stat.clear_done   = &clr_addr_ff;
      stat.in_request   = req_kind == KIND_REQUEST;
      stat.in_slot_ok   = 32'(req_slot_index) < SLOTS;
      stat.item_request = kind_ff == KIND_REQUEST;
      stat.miss         = !left_fit && !right_fit;
      stat.next_leaf    = chosen[NODE_BITS-1];
      stat.grant_ok     = grant_ok;
      stat.at_root      = node_ff == NODE_BITS'(1);
      stat.rsp_free     = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_granted_slot = rsp_slot_ff;

endmodule

`default_nettype wire

/* hdl/first_fit_capacity_allocator_top.sv */
// first-fit capacity allocator over a max tree of per-slot free capacity
//
// req_ch carries transactions: kind 0 loads slot_index with amount as its
// capacity and gives no response; kind 1 asks for amount and gives exactly
// one response on rsp_ch: the 1-based number of the lowest slot below the
// slot count that held at least amount (that slot is then reduced by
// amount), or 0 when no such slot exists.
// csr_write_en / csr_write_data set the slot count (reset value 1024);
// write it only while no transaction is in flight.
// sequence: a load is accepted, then writes one tree node per level on the
// way up (11 levels); a granted request is accepted, fetches the root
// children, descends 10 levels, grants, updates 11 levels on the way up and
// sets the response register; a request whose first fit lies at or above
// the slot count skips the update, and one where nothing fits goes to the
// response register right after the first descent step. one transaction is
// worked on at a time. after reset all 2048 tree nodes are cleared to zero,
// one node a cycle, with req_ch.ready low.
// the response sits in an output register, so the next transaction is taken
// while it waits; a request that finishes while that register is still full
// holds until rsp_ch.ready frees it.
`default_nettype none

module first_fit_capacity_allocator_top import ffca_pkg::*; (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_write_en,
   input  wire logic [SLOT_COUNT_BITS-1:0] csr_write_data,
   ffca_req_if.sink                        req_ch,
   ffca_rsp_if.source                      rsp_ch
);

   cmd_type  cmd;
   stat_type stat;
   logic     req_ready;

   ffca_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .stat      (stat),
      .req_ready (req_ready),
      .cmd       (cmd)
   );

   ffca_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .csr_write_en     (csr_write_en),
      .csr_write_data   (csr_write_data),
      .req_kind         (req_ch.kind),
      .req_slot_index   (req_ch.slot_index),
      .req_amount       (req_ch.amount),
      .rsp_ready        (rsp_ch.ready),
      .stat             (stat),
      .rsp_valid        (rsp_ch.valid),
      .rsp_granted_slot (rsp_ch.granted_slot)
   );

   assign req_ch.ready = req_ready;

   // only one datapath operation is commanded per cycle
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clear_step, cmd.start, cmd.fetch, cmd.descend,
                cmd.grant, cmd.update, cmd.emit}))
      else $error("more than one datapath command at once");

   // an emitted response shows up on the output the next cycle
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_ch.valid)
      else $error("emitted response not presented");

   // the descent always follows the first child fetch
   assert property (@(posedge clock) disable iff (reset)
      cmd.fetch |=> cmd.descend)
      else $error("fetch not followed by descent");

   // a request whose first fit lies outside the slot count modifies no slot
   assert property (@(posedge clock) disable iff (reset)
      (cmd.grant && !stat.grant_ok) |=> !cmd.update)
      else $error("update started for a slot outside the slot count");

endmodule

`default_nettype wire

/* bench/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
   import ffca_pkg::*;

   localparam int CLOCK_PERIOD    = 4;
   localparam int SETTLE_CYCLES   = 40;
   localparam int HOLD_CYCLES     = 400;
   localparam int WATCHDOG_LIMIT  = 10000;
   localparam int ITEMS_PER_PHASE = 140;
   localparam int PHASES          = 8;
   localparam int DIRECTED_ROWS   = 29;

   typedef enum {OP_LOAD, OP_REQUEST, OP_SET_COUNT} stim_op_type;

   typedef struct {
      stim_op_type            op;
      int unsigned            arg;
      logic [AMOUNT_BITS-1:0] amount;
      bit                     known;
      logic [GRANT_BITS-1:0]  grant;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_en;
   logic [SLOT_COUNT_BITS-1:0] csr_write_data;

   ffca_req_if req_ch ();
   ffca_rsp_if rsp_ch ();

   first_fit_capacity_allocator_top DUT (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // shadow of the capacity tree: node 1 is the root, leaves from LEAF_BASE
   logic [VALUE_BITS-1:0]      cap_tree [TREE_NODES];
   logic [SLOT_COUNT_BITS-1:0] slot_count_shadow;
   logic [GRANT_BITS-1:0]      expected_grants [$];

   int mismatch_count   = 0;
   bit req_steady       = 1'b0;
   bit rsp_steady       = 1'b0;
   bit rsp_hold_pending = 1'b0;

   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{OP_SET_COUNT, 1024, 32'd0,          1'b0, 11'd0},
      '{OP_REQUEST,   0,    32'd0,          1'b1, 11'd1},
      '{OP_REQUEST,   1023, 32'd1,          1'b1, 11'd0},
      '{OP_REQUEST,   0,    32'hFFFF_FFFF,  1'b1, 11'd0},
      '{OP_LOAD,      1023, 32'hFFFF_FFFF,  1'b0, 11'd0},
      '{OP_REQUEST,   0,    32'hFFFF_FFFF,  1'b1, 11'd1024},
      '{OP_REQUEST,   0,    32'd1,          1'b1, 11'd0},
      '{OP_LOAD,      0,    32'd100,        1'b0, 11'd0},
      '{OP_LOAD,      5,    32'd500,        1'b0, 11'd0},
      '{OP_REQUEST,   0,    32'd40,         1'b0, 11'd0},
      '{OP_REQUEST,   0,    32'd61,         1'b0, 11'd0},
      '{OP_REQUEST,   0,    32'd60,         1'b0, 11'd0},
      '{OP_LOAD,      1023, 32'h8000_0000,  1'b0, 11'd0},
      '{OP_LOAD,      512,  32'd7,          1'b0, 11'd0},
      '{OP_REQUEST,   0,    32'd7,          1'b0, 11'd0},
      '{OP_REQUEST,   0,    32'h8000_0000,  1'b0, 11'd0},
      '{OP_SET_COUNT, 0,    32'd0,          1'b0, 11'd0},
      '{OP_REQUEST,   0,    32'd0,          1'b1, 11'd0},
      '{OP_LOAD,      3,    32'd9,          1'b0, 11'd0},
      '{OP_REQUEST,   0,    32'd9,          1'b1, 11'd0},
      '{OP_SET_COUNT, 1,    32'd0,          1'b0, 11'd0},
      '{OP_LOAD,      0,    32'd5,          1'b0, 11'd0},
      '{OP_REQUEST,   0,    32'd5,          1'b0, 11'd0},
      '{OP_REQUEST,   0,    32'd9,          1'b0, 11'd0},
      '{OP_SET_COUNT, 2047, 32'd0,          1'b0, 11'd0},
      '{OP_LOAD,      682,  32'h5555_5555,  1'b0, 11'd0},
      '{OP_LOAD,      341,  32'hAAAA_AAAA,  1'b0, 11'd0},
      '{OP_REQUEST,   0,    32'hAAAA_AAAA,  1'b0, 11'd0},
      '{OP_REQUEST,   0,    32'h5555_5555,  1'b0, 11'd0}
   };

   function automatic int unsigned random_gap();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 85) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic void store_capacity(input int unsigned slot,
                                          input logic [VALUE_BITS-1:0] cap);
      int unsigned node;
      node = LEAF_BASE + slot;
      cap_tree[node] = cap;
      while (node > 1) begin
         node = node >> 1;
         cap_tree[node] = (cap_tree[2*node] > cap_tree[2*node+1]) ?
                          cap_tree[2*node] : cap_tree[2*node+1];
      end
   endfunction

   // returns 1 when the transaction produces a response, updating the shadow tree
   function automatic bit first_fit_grant(input logic [KIND_BITS-1:0] kind,
                                          input logic [SLOT_BITS-1:0] slot,
                                          input logic [AMOUNT_BITS-1:0] amount,
                                          output logic [GRANT_BITS-1:0] grant);
      int unsigned node;
      int unsigned found;
      int unsigned usable;
      grant = '0;
      if (kind == KIND_LOAD) begin
         if (slot < SLOTS) store_capacity(slot, amount);
         return 1'b0;
      end
      usable = (slot_count_shadow > SLOTS) ? SLOTS : slot_count_shadow;
      if (cap_tree[1] < amount) return 1'b1;
      node = 1;
      while (node < LEAF_BASE)
         node = (cap_tree[2*node] >= amount) ? 2*node : 2*node + 1;
      found = node - LEAF_BASE;
      if (found >= usable) return 1'b1;
      store_capacity(found, cap_tree[node] - amount);
      grant = GRANT_BITS'(found + 1);
      return 1'b1;
   endfunction

   task automatic send_item(input logic [KIND_BITS-1:0] kind,
                            input logic [SLOT_BITS-1:0] slot,
                            input logic [AMOUNT_BITS-1:0] amount,
                            input bit known,
                            input logic [GRANT_BITS-1:0] typed_grant);
      int unsigned gap;
      logic [GRANT_BITS-1:0] grant;
      gap = req_steady ? 0 : random_gap();
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.kind       <= kind;
      req_ch.slot_index <= slot;
      req_ch.amount     <= amount;
      do @(posedge clock); while (!req_ch.ready);
      if (first_fit_grant(kind, slot, amount, grant))
         expected_grants.push_back(known ? typed_grant : grant);
   endtask

   // pause the sender until every grant is back and any load has finished
   task automatic settle_idle();
      req_ch.valid <= 1'b0;
      while (expected_grants.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_slot_count(input logic [SLOT_COUNT_BITS-1:0] count);
      settle_idle();
      csr_write_en   <= 1'b1;
      csr_write_data <= count;
      @(posedge clock);
      csr_write_en <= 1'b0;
      slot_count_shadow = count;
   endtask

   // response side: checks every response and drives ready
   initial begin
      int unsigned gap_left;
      logic [GRANT_BITS-1:0] want;
      gap_left = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_grants.size() == 0) begin
               $error("granted_slot: expected none, actual %0d", rsp_ch.granted_slot);
               mismatch_count++;
            end else begin
               want = expected_grants.pop_front();
               if (rsp_ch.granted_slot !== want) begin
                  $error("granted_slot: expected %0d, actual %0d", want,
                         rsp_ch.granted_slot);
                  mismatch_count++;
               end
            end
         end
         if (rsp_hold_pending) begin
            rsp_hold_pending = 1'b0;
            gap_left = HOLD_CYCLES;
         end
         if (gap_left == 0 && !rsp_steady) gap_left = random_gap();
         if (gap_left != 0) begin
            rsp_ch.ready <= 1'b0;
            gap_left--;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // watchdog on cycles without any request or response handshake
   initial begin
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("first_fit_capacity_allocator_top regression: fail");
      $finish;
   end

   initial begin
      logic [SLOT_COUNT_BITS-1:0] phase_counts [PHASES];
      logic [KIND_BITS-1:0]       kind;
      logic [SLOT_BITS-1:0]       slot;
      logic [AMOUNT_BITS-1:0]     amount;
      int unsigned pick;
      int unsigned usable;
      int unsigned near_lo;
      int unsigned near_hi;
      int unsigned phase_items;

      foreach (cap_tree[n]) cap_tree[n] = '0;
      slot_count_shadow = SLOT_COUNT_RESET;
      csr_write_en      = 1'b0;
      csr_write_data    = '0;
      req_ch.valid      = 1'b0;
      req_ch.kind       = KIND_LOAD;
      req_ch.slot_index = '0;
      req_ch.amount     = '0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         case (directed_rows[r].op)
            OP_SET_COUNT: begin
               write_slot_count(SLOT_COUNT_BITS'(directed_rows[r].arg));
            end
            OP_LOAD: begin
               send_item(KIND_LOAD, SLOT_BITS'(directed_rows[r].arg),
                         directed_rows[r].amount, 1'b0, '0);
            end
            default: begin
               send_item(KIND_REQUEST, SLOT_BITS'(directed_rows[r].arg),
                         directed_rows[r].amount, directed_rows[r].known,
                         directed_rows[r].grant);
            end
         endcase
      end

      phase_counts = '{11'd1024, 11'd1, 11'd2047, 11'd0,
                       SLOT_COUNT_BITS'($urandom_range(2, SLOTS - 1)), 11'd1025,
                       11'd1024, SLOT_COUNT_BITS'($urandom_range(1, 2047))};

      for (int phase = 0; phase < PHASES; phase++) begin
         write_slot_count(phase_counts[phase]);
         req_steady  = (phase % 3 == 2);
         rsp_steady  = (phase % 4 == 3);
         phase_items = (phase_counts[phase] == 0) ? 60 : ITEMS_PER_PHASE;
         usable      = (phase_counts[phase] > SLOTS) ? SLOTS : phase_counts[phase];
         near_lo     = (usable >= 2) ? usable - 2 : 0;
         near_hi     = (usable + 1 > SLOTS - 1) ? SLOTS - 1 : usable + 1;

         // back-pressure: the response side stalls while requests keep coming
         if (phase == 5) begin
            req_steady       = 1'b1;
            rsp_hold_pending = 1'b1;
            repeat (16)
               send_item(KIND_REQUEST, SLOT_BITS'($urandom),
                         AMOUNT_BITS'($urandom_range(0, 50)), 1'b0, '0);
            settle_idle();
            req_steady = 1'b0;
         end

         repeat (phase_items) begin
            kind = ($urandom_range(0, 99) < 45) ? KIND_LOAD : KIND_REQUEST;
            pick = $urandom_range(0, 99);
            if (pick < 40)      slot = SLOT_BITS'($urandom_range(0, 15));
            else if (pick < 70) slot = SLOT_BITS'($urandom_range(near_lo, near_hi));
            else                slot = SLOT_BITS'($urandom);
            pick = $urandom_range(0, 99);
            if (kind == KIND_LOAD) begin
               if (pick < 40)      amount = $urandom_range(0, 1000);
               else if (pick < 60) amount = $urandom;
               else if (pick < 70) amount = $urandom_range(0, 1) ? 32'hFFFF_FFFF
                                                                 : 32'h8000_0000;
               else                amount = $urandom_range(1000, 100000);
            end else begin
               if (pick < 50)      amount = $urandom_range(0, 400);
               else if (pick < 60) amount = '0;
               else if (pick < 75) amount = $urandom_range(0, 100000);
               else if (pick < 90) amount = $urandom;
               else                amount = 32'hFFFF_FFFF;
            end
            send_item(kind, slot, amount, 1'b0, '0);
         end
      end

      req_ch.valid <= 1'b0;
      while (expected_grants.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("first_fit_capacity_allocator_top regression: pass");
      else
         $display("first_fit_capacity_allocator_top regression: fail");
      $finish;
   end

endmodule

/* first_fit_capacity_allocator_top.f */
hdl/ffca_pkg.sv
hdl/ffca_if.sv
hdl/ffca_ctrl.sv
hdl/ffca_dp.sv
hdl/first_fit_capacity_allocator_top.sv
bench/tb_top.sv
